>>> design/md5_hash_engine_unit_defines.svh
// Assertion macros shared by the checker files of the MD5 engine.
// Each use expands to one labeled concurrent assertion.
`ifndef MD5_HASH_ENGINE_UNIT_DEFINES_SVH
`define MD5_HASH_ENGINE_UNIT_DEFINES_SVH

// Check a property on the rising clock, quiet while reset is held.
`define MD5_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the rising clock at every edge, reset included.
`define MD5_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/md5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 engine package
// Widths, initial chaining values, controller codes and the per-round
// constant tables of the compression function.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned WordAddrW  = 4;
  localparam int unsigned RoundW     = 6;
  localparam int unsigned LenW       = 64;

  typedef logic [WordW-1:0]     word_t;
  typedef logic [WordAddrW-1:0] waddr_t;
  typedef logic [RoundW-1:0]    round_t;

  localparam word_t IvA = 32'h67452301;
  localparam word_t IvB = 32'hefcdab89;
  localparam word_t IvC = 32'h98badcfe;
  localparam word_t IvD = 32'h10325476;

  localparam logic [7:0]  PadMark     = 8'h80;
  localparam round_t      LenPos      = 6'd56;
  localparam round_t      LastPos     = 6'd63;
  localparam round_t      LastRound   = 6'd63;
  localparam logic [1:0]  LastWordIdx = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } pad_e;

  typedef enum logic [1:0] {
    DEST_IDLE,
    DEST_PAD,
    DEST_OUT
  } dest_e;

  // Message word used by round j.
  function automatic waddr_t msg_index(input round_t j);
    logic [7:0] t;
    t = 8'd0;
    unique case (j[5:4])
      2'd0: t = {2'b00, j};
      2'd1: t = {2'b00, j} * 8'd5 + 8'd1;
      2'd2: t = {2'b00, j} * 8'd3 + 8'd5;
      2'd3: t = {2'b00, j} * 8'd7;
      default: t = 8'd0;
    endcase
    return t[3:0];
  endfunction

  // Left rotation of round j.
  function automatic logic [4:0] rot_amount(input round_t j);
    logic [4:0] s;
    s = 5'd0;
    unique case ({j[5:4], j[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Additive constant of round j (integer part of 2^32 * |sin(j+1)|).
  function automatic word_t sine_k(input round_t j);
    word_t k;
    k = '0;
    unique case (j)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

>>> design/md5_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 input channel
// Valid/ready channel carrying one message byte request per transfer.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (
    output valid, data_byte, byte_valid, end_of_message,
    input  ready
  );

  modport sink (
    input  valid, data_byte, byte_valid, end_of_message,
    output ready
  );
endinterface

>>> design/md5_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 output channel
// Valid/ready channel carrying one digest word request per transfer.
// ----------------------------------------------------------------------------
interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (
    output valid, digest_word, word_index, last_word,
    input  ready
  );

  modport sink (
    input  valid, digest_word, word_index, last_word,
    output ready
  );
endinterface

>>> design/md5_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/md5_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 round function
// New B word of one compression round from the working words.
// ----------------------------------------------------------------------------
module md5_round
  import md5_pkg::*;
(
  input  word_t      a_i,
  input  word_t      b_i,
  input  word_t      c_i,
  input  word_t      d_i,
  input  word_t      msg_i,
  input  word_t      k_i,
  input  logic [4:0] rot_i,
  input  logic [1:0] sel_i,
  output word_t      b_o
);

  word_t                f;
  word_t                sum;
  logic [2*WordW-1:0]   rot_wide;

  always_comb begin
    unique case (sel_i)
      2'd0:    f = (b_i & c_i) | (~b_i & d_i);
      2'd1:    f = (d_i & b_i) | (~d_i & c_i);
      2'd2:    f = b_i ^ c_i ^ d_i;
      default: f = c_i ^ (b_i | ~d_i);
    endcase
  end

  assign sum      = a_i + f + k_i + msg_i;
  assign rot_wide = {sum, sum} << rot_i;
  assign b_o      = b_i + rot_wide[2*WordW-1:WordW];

endmodule

>>> design/md5_hash_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 hash engine
// Streaming MD5: bytes in, four digest words out per message.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one request per message byte (data_byte, byte_valid,
//           end_of_message). byte_valid=0 without end_of_message is a no-op.
//   out_o : four requests per message, words A, B, C, D (word_index 0..3),
//           last_word set on D. Digest bytes are little-endian in each word.
// Sequence:
//   Byte requests are taken while the engine is idle. The 64th byte of a block
//   starts a compression (one read-ahead of the block RAM, 64 rounds at
//   one round per cycle, one fold into the chaining words). The final request
//   adds padding at one byte per cycle (9 to 72 bytes) plus one or two
//   compressions, then the four digest words. No byte is taken while a
//   compression runs on the single-round datapath.
// Reset: chaining words return to the MD5 initial values, length and fill
//   position to zero. The block RAM is not cleared; every word is written
//   before a compression reads it.
// Stall: while out_o is stalled, hold the current digest word; in_i stays
//   not ready until the D word is taken.
// ----------------------------------------------------------------------------
module md5_hash_engine_unit
  import md5_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);

  state_e state_q, state_d;
  pad_e   phase_q, phase_d;
  dest_e  dest_q,  dest_d;

  round_t          fill_q;     // byte position within the current block
  round_t          round_q;
  logic [LenW-1:0] len_q;      // message length in bits
  word_t           pack_q;     // partial word being assembled
  word_t           chain_a_q, chain_b_q, chain_c_q, chain_d_q;
  word_t           wa_q, wb_q, wc_q, wd_q;
  logic [1:0]      idx_q;

  logic       put_en;
  logic [7:0] put_byte;
  logic       in_take;
  logic       out_take;
  waddr_t     ram_raddr;
  word_t      ram_rdata;
  word_t      round_b;
  round_t     round_next;
  logic [7:0] len_byte;

  assign in_take    = in_i.valid && in_i.ready;
  assign out_take   = out_o.valid && out_o.ready;
  assign round_next = round_q + 6'd1;

  // Length bytes go out little-endian at fill positions 56..63.
  assign len_byte = len_q[{fill_q[2:0], 3'b000} +: 8];

  // --------------------------------------------------------------------------
  // Controller: byte intake, padding, compression sequencing, digest output.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    dest_d      = dest_q;
    put_en      = 1'b0;
    put_byte    = in_i.data_byte;
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          put_en  = in_i.byte_valid;
          phase_d = PAD_MARK;
          if (in_i.byte_valid && (fill_q == LastPos)) begin
            state_d = ST_LOAD;
            dest_d  = in_i.end_of_message ? DEST_PAD : DEST_IDLE;
          end else if (in_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        put_en = 1'b1;
        priority if (phase_q == PAD_MARK) begin
          put_byte = PadMark;
          phase_d  = PAD_ZERO;
        end else if (phase_q == PAD_LEN || fill_q == LenPos) begin
          put_byte = len_byte;
          phase_d  = PAD_LEN;
        end else begin
          put_byte = 8'h00;
        end
        if (fill_q == LastPos) begin
          // The last length byte closes the message; otherwise keep padding.
          state_d = ST_LOAD;
          dest_d  = (phase_q == PAD_LEN) ? DEST_OUT : DEST_PAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_q == LastRound) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        unique case (dest_q)
          DEST_PAD: state_d = ST_PAD;
          DEST_OUT: state_d = ST_OUT;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        out_o.valid = 1'b1;
        if (out_o.ready && (idx_q == LastWordIdx)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PAD_MARK;
      dest_q  <= DEST_IDLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      dest_q  <= dest_d;
    end
  end

  // --------------------------------------------------------------------------
  // Block store: bytes pack into a word, full words go to the RAM.
  // Read one word ahead so the registered data meets its round.
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (state_q)
      ST_ROUND: ram_raddr = msg_index(round_next);
      default:  ram_raddr = msg_index('0);
    endcase
  end

  md5_ram #(
    .Width (WordW),
    .Depth (BlockWords)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (put_en && (fill_q[1:0] == 2'd3)),
    .waddr_i (fill_q[5:2]),
    .wdata_i ({put_byte, pack_q[WordW-1:8]}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (put_en) begin
      pack_q <= {put_byte, pack_q[WordW-1:8]};
    end
  end

  // --------------------------------------------------------------------------
  // Compression datapath: one round per cycle on the working words.
  // --------------------------------------------------------------------------
  md5_round u_round (
    .a_i   (wa_q),
    .b_i   (wb_q),
    .c_i   (wc_q),
    .d_i   (wd_q),
    .msg_i (ram_rdata),
    .k_i   (sine_k(round_q)),
    .rot_i (rot_amount(round_q)),
    .sel_i (round_q[5:4]),
    .b_o   (round_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      round_q   <= '0;
      len_q     <= '0;
      wa_q      <= '0;
      wb_q      <= '0;
      wc_q      <= '0;
      wd_q      <= '0;
      chain_a_q <= IvA;
      chain_b_q <= IvB;
      chain_c_q <= IvC;
      chain_d_q <= IvD;
      idx_q     <= '0;
    end else begin
      if (put_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (in_take && in_i.byte_valid) begin
        len_q <= len_q + LenW'(8);
      end
      unique case (state_q)
        ST_LOAD: begin
          wa_q    <= chain_a_q;
          wb_q    <= chain_b_q;
          wc_q    <= chain_c_q;
          wd_q    <= chain_d_q;
          round_q <= '0;
        end
        ST_ROUND: begin
          wa_q    <= wd_q;
          wb_q    <= round_b;
          wc_q    <= wb_q;
          wd_q    <= wc_q;
          round_q <= round_next;
        end
        ST_FOLD: begin
          chain_a_q <= chain_a_q + wa_q;
          chain_b_q <= chain_b_q + wb_q;
          chain_c_q <= chain_c_q + wc_q;
          chain_d_q <= chain_d_q + wd_q;
        end
        ST_OUT: begin
          if (out_take) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == LastWordIdx) begin
              // Drop the finished message and restart from the initial values.
              chain_a_q <= IvA;
              chain_b_q <= IvB;
              chain_c_q <= IvC;
              chain_d_q <= IvD;
              len_q     <= '0;
              fill_q    <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Digest output, straight from the chaining registers.
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (idx_q)
      2'd0:    out_o.digest_word = chain_a_q;
      2'd1:    out_o.digest_word = chain_b_q;
      2'd2:    out_o.digest_word = chain_c_q;
      default: out_o.digest_word = chain_d_q;
    endcase
  end

  assign out_o.word_index = idx_q;
  assign out_o.last_word  = (idx_q == LastWordIdx);

endmodule

>>> design/md5_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 engine port checker
// Watches the top-level channels over time; attached by bind.
// ----------------------------------------------------------------------------
`include "md5_hash_engine_unit_defines.svh"

module md5_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_index_i,
  input logic       out_last_i
);

  // Hold a stalled digest request.
  `MD5_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "digest request dropped while stalled")

  // Never take a byte while the digest is going out.
  `MD5_ASSERT_RST(a_no_overlap, clk_i, rst_ni, !(in_ready_i && out_valid_i), "input ready during digest output")

  // Last word flag only on word D.
  `MD5_ASSERT_RST(a_last_is_d, clk_i, rst_ni, out_valid_i && out_last_i |-> out_index_i == 2'd3, "last_word on a word other than D")

  // Advance the word index by one after each taken word that is not the last.
  `MD5_ASSERT_RST(a_index_step, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_index_i == $past(out_index_i) + 2'd1, "digest word index did not advance")

  // Return to byte intake right after the D word is taken.
  `MD5_ASSERT_RST(a_back_to_idle, clk_i, rst_ni, out_valid_i && out_ready_i && out_last_i |=> in_ready_i && !out_valid_i, "engine not idle after digest")

endmodule

bind md5_hash_engine_unit md5_chk u_md5_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.word_index),
  .out_last_i  (out_o.last_word)
);

>>> bench/md5_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 engine bench package
// Digest predictor and scoreboard for the streaming MD5 engine bench.
// ----------------------------------------------------------------------------
package md5_tb_pkg;
  import md5_pkg::*;

  typedef struct {
    word_t      digest_word;
    logic [1:0] word_index;
    logic       last_word;
  } digest_rec_t;

  localparam word_t RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned RotLeft [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  class md5_digest_tracker;
    word_t       chain_w [4];
    word_t       block_w [16];
    logic [5:0]  fill_pos;
    logic [63:0] bit_len;
    int unsigned mismatches;
    digest_rec_t expected_words [$];

    function new();
      mismatches = 0;
      foreach (block_w[i]) block_w[i] = '0;
      restart_chain();
    endfunction

    function void restart_chain();
      chain_w[0] = 32'h67452301;
      chain_w[1] = 32'hefcdab89;
      chain_w[2] = 32'h98badcfe;
      chain_w[3] = 32'h10325476;
      bit_len    = '0;
      fill_pos   = '0;
    endfunction

    function word_t rotl(word_t x, int unsigned n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress_block();
      word_t a, b, c, d, f, t;
      int unsigned g;
      a = chain_w[0];
      b = chain_w[1];
      c = chain_w[2];
      d = chain_w[3];
      for (int unsigned j = 0; j < 64; j++) begin
        if (j < 16) begin
          f = (b & c) | (~b & d);
          g = j;
        end else if (j < 32) begin
          f = (d & b) | (~d & c);
          g = (5 * j + 1) % 16;
        end else if (j < 48) begin
          f = b ^ c ^ d;
          g = (3 * j + 5) % 16;
        end else begin
          f = c ^ (b | ~d);
          g = (7 * j) % 16;
        end
        t = d;
        d = c;
        c = b;
        b = b + rotl(a + f + RoundConst[j] + block_w[g], RotLeft[(j / 16) * 4 + j % 4]);
        a = t;
      end
      chain_w[0] += a;
      chain_w[1] += b;
      chain_w[2] += c;
      chain_w[3] += d;
    endfunction

    // Pack one byte little-endian; compress when the block is full.
    function void absorb_byte(logic [7:0] data_b);
      if (fill_pos[1:0] == 2'd0) begin
        block_w[fill_pos[5:2]] = {24'd0, data_b};
      end else begin
        block_w[fill_pos[5:2]] |= word_t'(data_b) << (8 * fill_pos[1:0]);
      end
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) compress_block();
    endfunction

    function void absorb_request(logic [7:0] data_b, logic byte_valid, logic end_of_message);
      logic [63:0] msg_len;
      digest_rec_t rec;
      if (byte_valid) begin
        absorb_byte(data_b);
        bit_len = bit_len + 64'd8;
      end
      if (!end_of_message) return;
      msg_len = bit_len;
      absorb_byte(PadMark);
      while (fill_pos != LenPos) absorb_byte(8'h00);
      for (int k = 0; k < 8; k++) absorb_byte(msg_len[8*k +: 8]);
      for (int k = 0; k < 4; k++) begin
        rec.digest_word = chain_w[k];
        rec.word_index  = 2'(k);
        rec.last_word   = (k == 3);
        expected_words.push_back(rec);
      end
      restart_chain();
    endfunction

    function void compare_digest_word(word_t digest_word, logic [1:0] word_index,
                                      logic last_word);
      digest_rec_t rec;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected digest word %h idx %0d last %0b",
                 $time, digest_word, word_index, last_word);
        return;
      end
      rec = expected_words.pop_front();
      if (digest_word !== rec.digest_word) begin
        mismatches++;
        $display("%0t: digest_word expected %h actual %h",
                 $time, rec.digest_word, digest_word);
      end
      if (word_index !== rec.word_index) begin
        mismatches++;
        $display("%0t: word_index expected %0d actual %0d",
                 $time, rec.word_index, word_index);
      end
      if (last_word !== rec.last_word) begin
        mismatches++;
        $display("%0t: last_word expected %0b actual %0b",
                 $time, rec.last_word, last_word);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 hash engine bench
// Streams messages of many lengths byte by byte into the engine and checks
// every digest word against a predictor, with bursty input and a stalling
// output side, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import md5_pkg::*;
  import md5_tb_pkg::*;

  logic clk_i;
  logic rst_ni;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  md5_hash_engine_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  md5_digest_tracker digest_tracker = new();

  // Sender burst state and stimulus bookkeeping.
  int unsigned burst_left   = 0;
  int unsigned msg_items    = 0;
  int unsigned msgs_done    = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_off_req = 1'b0;

  localparam int unsigned RandItems   = 280;
  localparam int unsigned MinMessages = 6;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = 300;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Offer one request and hold it until the engine takes it. Gaps between
  // bursts keep valid low for a random number of cycles.
  task automatic send_request(input logic [7:0] data_b, input logic byte_valid,
                              input logic end_of_message);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // Mix in long unbroken bursts now and then.
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(64, 160)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= data_b;
    in_ch.byte_valid     <= byte_valid;
    in_ch.end_of_message <= end_of_message;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    digest_tracker.absorb_request(data_b, byte_valid, end_of_message);
  endtask

  // Drop valid and hold off until every predicted digest word is taken.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (digest_tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Send one message of len bytes. With end_on_byte the final byte carries
  // end_of_message, otherwise a separate empty final request closes it.
  // With sprinkle_idle, idle requests are sprinkled in as noise.
  task automatic send_message(input int unsigned len, input bit end_on_byte,
                              input bit sprinkle_idle);
    logic fill_ones;
    logic [7:0] data_b;
    fill_ones = ($urandom_range(0, 9) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if (sprinkle_idle && $urandom_range(0, 7) == 0) begin
        send_request(8'($urandom), 1'b0, 1'b0);
      end
      data_b = fill_ones ? 8'hff : 8'($urandom);
      send_request(data_b, 1'b1, end_on_byte && (i == len - 1));
      msg_items++;
    end
    if (!end_on_byte || len == 0) begin
      send_request(8'($urandom), 1'b0, 1'b1);
      msg_items++;
    end
    msgs_done++;
  endtask

  // Receiver: take digest words and stall on its own pattern, with one long
  // hold-off on request.
  initial begin : rx_proc
    int unsigned run_left;
    int unsigned hold_cnt;
    logic        rdy_val;
    run_left = 0;
    hold_cnt = 0;
    rdy_val  = 1'b1;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        digest_tracker.compare_digest_word(out_ch.digest_word, out_ch.word_index,
                                           out_ch.last_word);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        if (hold_cnt == 0) hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_cnt = HoldCycles;
        out_ch.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          // Pick either a steady ready stretch or a short toggle run.
          if ($urandom_range(0, 4) == 0) begin
            rdy_val  = 1'b1;
            run_left = $urandom_range(40, 120);
          end else begin
            rdy_val  = ~rdy_val;
            run_left = $urandom_range(1, 6);
          end
        end
        run_left--;
        out_ch.ready <= rdy_val;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stim_proc
    int unsigned len;
    int unsigned pick;
    int unsigned special_len [12];
    special_len = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    rst_ni               <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= 8'h00;
    in_ch.byte_valid     <= 1'b0;
    in_ch.end_of_message <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle request, empty message, one-byte messages at the byte
    // extremes, a short message closed by an empty final request, a two-byte
    // message, and an empty message right after noise.
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h7f, 1'b1, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    // Pause the sender until every digest word has come back.
    wait_drained();

    // Random messages; padding boundaries are drawn often.
    while (msg_items < RandItems || msgs_done < MinMessages) begin
      if (msgs_done == 3) begin
        // Hold the receiver off and keep offering so the engine fills up.
        wait_drained();
        hold_off_req = 1'b1;
        send_message($urandom_range(1, 20), 1'b1, 1'b0);
        send_message($urandom_range(20, 40), 1'b0, 1'b0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        len = special_len[$urandom_range(0, 11)];
      end else begin
        len = $urandom_range(1, 30);
      end
      send_message(len, $urandom_range(0, 1), $urandom_range(0, 2) == 0);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (digest_tracker.mismatches == 0 && digest_tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (digest_tracker.pending() != 0) begin
        $display("%0t: %0d digest words never arrived", $time, digest_tracker.pending());
      end
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("%0t: timeout with %0d digest words outstanding", $time,
             digest_tracker.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/md5_pkg.sv
design/md5_in_if.sv
design/md5_out_if.sv
design/md5_ram.sv
design/md5_round.sv
design/md5_hash_engine_unit.sv
design/md5_chk.sv
bench/md5_tb_pkg.sv
bench/tb_top.sv
